@@ hdl/pfcp_pkg.sv @@
// Shared constants, codes and types of the prime factor count prefix table.
`timescale 1ns / 1ps
package pfcp_pkg;

	localparam int MAX_N    = 65536;
	localparam int ADDR_W   = $clog2(MAX_N);
	localparam int IDX_W    = 16;
	localparam int TOTAL_W  = 21;
	localparam int STATUS_W = 2;
	localparam int S_DATA_W = 2 * IDX_W;
	localparam int M_DATA_W = ((TOTAL_W + STATUS_W + 7) / 8) * 8;
	localparam int M_PAD_W  = M_DATA_W - TOTAL_W - STATUS_W;

	localparam logic KIND_BUILD = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_NOT_BUILT = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_RANGE     = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_ORDER     = 2'd3;

	typedef struct packed {
		logic               rd_en;
		logic [ADDR_W-1:0]  rd_addr;
		logic               wr_en;
		logic [ADDR_W-1:0]  wr_addr;
		logic [TOTAL_W-1:0] wr_data;
	} mem_req_t;

endpackage

@@ hdl/prime_factor_count_prefix_table.sv @@
// Prime factor count prefix table top: query path, output register, build FSM, table RAM.
//
// Usage: the input stream carries build and range-query beats (tuser selects the kind),
// the output stream returns one result beat per input beat, in order. The limit register
// is written through cfg_wr_en/cfg_wr_data; the user must do this while the block is idle,
// as the block itself leaves it unchecked. A build clears the table, sieves it and forms
// prefix sums of the prime factor counts: it clears entries 0..L, tests each number 2..L
// for a prime (a zero entry), adds one at every multiple of each prime power up to L, then
// sums entries 0..L in order, with L the effective limit; all of it uses the one table RAM.
// A query reads two table entries through the one read port, so the next beat waits
// until the second read is issued; the result is loaded into the output register once
// it is free. Errors report through the status field with a zero total.
// Reset clears the control state and marks the table as not built; the limit register
// returns to 65535. When the receiver stalls, the result waits in the output register,
// one more item may still be accepted, and input is held off until the slot drains.
`timescale 1ns / 1ps
module prime_factor_count_prefix_table (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [pfcp_pkg::IDX_W-1:0]     cfg_wr_data,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// upper_index, lower_index
	input  logic [pfcp_pkg::S_DATA_W-1:0]  s_axis_tdata,
	// kind
	input  logic                           s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// factor_total, status, zero fill
	output logic [pfcp_pkg::M_DATA_W-1:0]  m_axis_tdata
);
	import pfcp_pkg::*;

	localparam logic [1:0] T_IDLE  = 2'd0;
	localparam logic [1:0] T_QB    = 2'd1;
	localparam logic [1:0] T_BUILD = 2'd2;

	logic [1:0]          state_q;
	logic [IDX_W-1:0]    upper_limit_q;
	logic                table_ready_q;
	logic [ADDR_W-1:0]   built_limit_q;
	logic [ADDR_W-1:0]   lim_q;
	logic [IDX_W-1:0]    b_q;
	logic [TOTAL_W-1:0]  pa_q;
	logic                ok_q;
	logic [STATUS_W-1:0] status_q;
	logic                pend_q;
	logic                out_valid_q;
	logic [TOTAL_W-1:0]  out_total_q;
	logic [STATUS_W-1:0] out_status_q;

	logic                in_acc;
	logic                out_free;
	logic                finish;
	logic [IDX_W-1:0]    a_in;
	logic [IDX_W-1:0]    b_in;
	logic [STATUS_W-1:0] st_calc;
	logic [ADDR_W-1:0]   lim_calc;
	logic                build_start;
	logic                build_done;
	mem_req_t            build_req;
	mem_req_t            req;
	logic [TOTAL_W-1:0]  rd_data;

	assign a_in        = s_axis_tdata[IDX_W-1:0];
	assign b_in        = s_axis_tdata[2*IDX_W-1:IDX_W];
	assign out_free    = !out_valid_q || m_axis_tready;
	assign finish      = pend_q && out_free;
	assign s_axis_tready = (state_q == T_IDLE) && (!pend_q || out_free);
	assign in_acc      = s_axis_tvalid && s_axis_tready;
	assign build_start = in_acc && (s_axis_tuser == KIND_BUILD);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{M_PAD_W{1'b0}}, out_status_q, out_total_q};

	always_comb begin
		if (32'(upper_limit_q) > 32'(MAX_N - 1)) begin
			lim_calc = ADDR_W'(MAX_N - 1);
		end else begin
			lim_calc = ADDR_W'(upper_limit_q);
		end
	end

	always_comb begin
		if (!table_ready_q) begin
			st_calc = STAT_NOT_BUILT;
		end else if (a_in == '0 || b_in == '0 || 32'(a_in) > 32'(built_limit_q)
				|| 32'(b_in) > 32'(built_limit_q)) begin
			st_calc = STAT_RANGE;
		end else if (b_in > a_in) begin
			st_calc = STAT_ORDER;
		end else begin
			st_calc = STAT_OK;
		end
	end

	always_comb begin
		if (state_q == T_BUILD) begin
			req = build_req;
		end else begin
			req         = '0;
			req.rd_en   = (in_acc && (s_axis_tuser == KIND_QUERY)) || (state_q == T_QB);
			req.rd_addr = (state_q == T_QB) ? ADDR_W'(b_q) : ADDR_W'(a_in);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= T_IDLE;
			upper_limit_q <= IDX_W'(65535);
			table_ready_q <= 1'b0;
			built_limit_q <= '0;
			pend_q        <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				upper_limit_q <= cfg_wr_data;
			end
			if (finish) begin
				pend_q      <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				T_IDLE: begin
					if (in_acc) begin
						state_q <= (s_axis_tuser == KIND_BUILD) ? T_BUILD : T_QB;
					end
				end
				T_QB: begin
					pend_q  <= 1'b1;
					state_q <= T_IDLE;
				end
				T_BUILD: begin
					if (build_done) begin
						table_ready_q <= 1'b1;
						built_limit_q <= lim_q;
						pend_q        <= 1'b1;
						state_q       <= T_IDLE;
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_total_q  <= ok_q ? pa_q - rd_data : '0;
			out_status_q <= status_q;
		end
		case (state_q)
			T_IDLE: begin
				if (in_acc) begin
					lim_q    <= lim_calc;
					b_q      <= b_in;
					status_q <= (s_axis_tuser == KIND_BUILD) ? STAT_OK : st_calc;
					ok_q     <= (s_axis_tuser == KIND_QUERY) && (st_calc == STAT_OK);
				end
			end
			T_QB: begin
				pa_q <= rd_data;
			end
			default: begin
			end
		endcase
	end

	pfcp_build u_build (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (build_start),
		.lim     (lim_q),
		.rd_data (rd_data),
		.req     (build_req),
		.done    (build_done)
	);

	pfcp_ram #(
		.WIDTH (TOTAL_W),
		.DEPTH (MAX_N)
	) u_table (
		.clk     (clk),
		.wr_en   (req.wr_en),
		.wr_addr (req.wr_addr),
		.wr_data (req.wr_data),
		.rd_en   (req.rd_en),
		.rd_addr (req.rd_addr),
		.rd_data (rd_data)
	);

endmodule

@@ hdl/pfcp_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module pfcp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ hdl/pfcp_build.sv @@
// Build sequencer: clears the table, sieves prime-power multiples and forms prefix sums.
`timescale 1ns / 1ps
module pfcp_build (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [pfcp_pkg::ADDR_W-1:0]   lim,
	input  logic [pfcp_pkg::TOTAL_W-1:0]  rd_data,
	output pfcp_pkg::mem_req_t            req,
	output logic                          done
);
	import pfcp_pkg::*;

	localparam logic [2:0] B_IDLE = 3'd0;
	localparam logic [2:0] B_CLR  = 3'd1;
	localparam logic [2:0] B_TEST = 3'd2;
	localparam logic [2:0] B_CHK  = 3'd3;
	localparam logic [2:0] B_RUN  = 3'd4;
	localparam logic [2:0] B_POW  = 3'd5;
	localparam logic [2:0] B_PCMP = 3'd6;
	localparam logic [2:0] B_SUM  = 3'd7;

	localparam logic [ADDR_W:0] ONE = (ADDR_W + 1)'(1);
	localparam logic [ADDR_W:0] TWO = (ADDR_W + 1)'(2);

	logic [2:0]          state_q;
	logic [ADDR_W:0]     cnt_q;
	logic [ADDR_W:0]     j_q;
	logic [ADDR_W-1:0]   p_q;
	logic [ADDR_W-1:0]   q_q;
	logic [2*ADDR_W-1:0] prod_q;
	logic                wr_pend_q;
	logic                wr_sum_q;
	logic [ADDR_W-1:0]   wr_addr_q;
	logic [TOTAL_W-1:0]  acc_q;

	logic [ADDR_W:0]     lim_ext;
	logic [TOTAL_W-1:0]  sum_val;

	assign lim_ext = {1'b0, lim};
	assign sum_val = acc_q + rd_data;
	assign done    = (state_q == B_SUM) && (j_q > lim_ext);

	always_comb begin
		req = '0;
		case (state_q)
			B_CLR: begin
				req.wr_en   = 1'b1;
				req.wr_addr = j_q[ADDR_W-1:0];
				req.wr_data = (j_q == ONE) ? TOTAL_W'(1) : '0;
			end
			B_TEST: begin
				req.rd_en   = (cnt_q <= lim_ext);
				req.rd_addr = cnt_q[ADDR_W-1:0];
			end
			B_RUN, B_SUM: begin
				req.rd_en   = (j_q <= lim_ext);
				req.rd_addr = j_q[ADDR_W-1:0];
			end
			default: begin
			end
		endcase
		if (wr_pend_q) begin
			req.wr_en   = 1'b1;
			req.wr_addr = wr_addr_q;
			req.wr_data = wr_sum_q ? sum_val : rd_data + TOTAL_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			wr_pend_q <= 1'b0;
		end else begin
			wr_pend_q <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (start) begin
						state_q <= B_CLR;
					end
				end
				B_CLR: begin
					if (j_q == lim_ext) begin
						state_q <= B_TEST;
					end
				end
				B_TEST: begin
					state_q <= (cnt_q > lim_ext) ? B_SUM : B_CHK;
				end
				B_CHK: begin
					state_q <= (rd_data == '0) ? B_RUN : B_TEST;
				end
				B_RUN: begin
					if (j_q <= lim_ext) begin
						wr_pend_q <= 1'b1;
					end else begin
						state_q <= B_POW;
					end
				end
				B_POW: begin
					state_q <= B_PCMP;
				end
				B_PCMP: begin
					state_q <= (prod_q <= {{ADDR_W{1'b0}}, lim}) ? B_RUN : B_TEST;
				end
				B_SUM: begin
					if (j_q <= lim_ext) begin
						wr_pend_q <= 1'b1;
					end else begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_pend_q && wr_sum_q) begin
			acc_q <= sum_val;
		end
		case (state_q)
			B_IDLE: begin
				j_q <= '0;
			end
			B_CLR: begin
				j_q   <= j_q + ONE;
				cnt_q <= TWO;
			end
			B_TEST: begin
				j_q   <= '0;
				acc_q <= '0;
			end
			B_CHK: begin
				if (rd_data == '0) begin
					p_q <= cnt_q[ADDR_W-1:0];
					q_q <= cnt_q[ADDR_W-1:0];
					j_q <= cnt_q;
				end else begin
					cnt_q <= cnt_q + ONE;
				end
			end
			B_RUN: begin
				wr_sum_q  <= 1'b0;
				wr_addr_q <= j_q[ADDR_W-1:0];
				j_q       <= j_q + {1'b0, q_q};
			end
			B_POW: begin
				prod_q <= {{ADDR_W{1'b0}}, q_q} * {{ADDR_W{1'b0}}, p_q};
			end
			B_PCMP: begin
				if (prod_q <= {{ADDR_W{1'b0}}, lim}) begin
					q_q <= prod_q[ADDR_W-1:0];
					j_q <= {1'b0, prod_q[ADDR_W-1:0]};
				end else begin
					cnt_q <= cnt_q + ONE;
				end
			end
			B_SUM: begin
				wr_sum_q  <= 1'b1;
				wr_addr_q <= j_q[ADDR_W-1:0];
				j_q       <= j_q + ONE;
			end
			default: begin
			end
		endcase
	end

endmodule

@@ hdl/pfcp_check.sv @@
// Port-level checker for the prime factor count prefix table, bound to the top level.
`timescale 1ns / 1ps
module pfcp_check (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic                           s_axis_tuser,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [pfcp_pkg::M_DATA_W-1:0]  m_axis_tdata
);
	import pfcp_pkg::*;

	logic                seen_build_q;
	logic [TOTAL_W-1:0]  out_total;
	logic [STATUS_W-1:0] out_status;

	assign out_total  = m_axis_tdata[TOTAL_W-1:0];
	assign out_status = m_axis_tdata[TOTAL_W+STATUS_W-1:TOTAL_W];

	// A build beat seen on the input marks the table as possibly built.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_build_q <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_BUILD)) begin
			seen_build_q <= 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("Output beat changed or dropped while stalled.");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (out_status != STAT_OK) |-> (out_total == '0))
		else $error("Error result carries a nonzero total.");

	a_not_built: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !seen_build_q |-> (out_status == STAT_NOT_BUILT))
		else $error("Result before any build does not report a missing table.");

	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({s_axis_tready, m_axis_tvalid}))
		else $error("Handshake output is unknown.");

endmodule

bind prime_factor_count_prefix_table pfcp_check u_check (.*);

@@ sim/prime_factor_count_prefix_table_test.sv @@
// Testbench of the prime factor count prefix table: predicted sieve sums checked beat by beat.
`timescale 1ns / 1ps
module prime_factor_count_prefix_table_test;
	import pfcp_pkg::*;

	localparam int STALL_LIMIT = 3000000;
	localparam int BEATS_PER_PHASE = 233;

	typedef struct packed {
		logic [TOTAL_W-1:0]  total;
		logic [STATUS_W-1:0] status;
	} factor_result_t;

	class factor_scoreboard;
		int unsigned limit_reg;
		int unsigned built_lim;
		bit table_built;
		int unsigned smallest_prime [MAX_N];
		int unsigned omega [MAX_N];
		logic [TOTAL_W-1:0] prefix_sum [MAX_N];
		factor_result_t pending_results [$];
		int errors;

		function new();
			limit_reg = 65535;
			built_lim = 0;
			table_built = 1'b0;
			errors = 0;
		endfunction

		function void set_limit(logic [IDX_W-1:0] value);
			limit_reg = 32'(value);
		endfunction

		function void build_prefix();
			int unsigned lim;
			int unsigned i;
			longint unsigned j;
			lim = (limit_reg > MAX_N - 1) ? MAX_N - 1 : limit_reg;
			for (i = 0; i < MAX_N; i++)
				smallest_prime[i] = 0;
			omega[0] = 0;
			omega[1] = 1;
			for (i = 2; i <= lim; i++) begin
				if (smallest_prime[i] == 0) begin
					smallest_prime[i] = i;
					for (j = longint'(i) * i; j <= lim; j += i)
						if (smallest_prime[j] == 0)
							smallest_prime[j] = i;
				end
				if (smallest_prime[i] == i)
					omega[i] = 1;
				else
					omega[i] = omega[i / smallest_prime[i]] + 1;
			end
			prefix_sum[0] = '0;
			for (i = 1; i <= lim; i++)
				prefix_sum[i] = prefix_sum[i - 1] + omega[i][TOTAL_W-1:0];
			built_lim = lim;
			table_built = 1'b1;
		endfunction

		function void note_input(logic kind, logic [IDX_W-1:0] a, logic [IDX_W-1:0] b);
			factor_result_t r;
			r.total = '0;
			r.status = STAT_OK;
			if (kind == KIND_BUILD)
				build_prefix();
			else if (!table_built)
				r.status = STAT_NOT_BUILT;
			else if (a == 0 || b == 0 || a > built_lim || b > built_lim)
				r.status = STAT_RANGE;
			else if (b > a)
				r.status = STAT_ORDER;
			else
				r.total = prefix_sum[a] - prefix_sum[b];
			pending_results = {pending_results, r};
		endfunction

		task report(string msg);
			if (errors < 100)
				$display("mismatch at %0t: %s", $time, msg);
			errors++;
		endtask

		task check_result(logic [M_DATA_W-1:0] data);
			factor_result_t want;
			logic [TOTAL_W-1:0] got_total;
			logic [STATUS_W-1:0] got_status;
			got_total = data[TOTAL_W-1:0];
			got_status = data[TOTAL_W +: STATUS_W];
			if (pending_results.size() == 0) begin
				report($sformatf("result beat %h with nothing expected", data));
				return;
			end
			want = pending_results.pop_front();
			if (got_total !== want.total)
				report($sformatf("factor_total %0d, expected %0d", got_total, want.total));
			if (got_status !== want.status)
				report($sformatf("status %0d, expected %0d", got_status, want.status));
		endtask
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_wr_en = 1'b0;
	logic [IDX_W-1:0]    cfg_wr_data = '0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [S_DATA_W-1:0] s_axis_tdata = '0;
	logic                s_axis_tuser = 1'b0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [M_DATA_W-1:0] m_axis_tdata;

	int tx_idle = 0;
	int rx_idle = 0;
	int stall_cycles = 0;
	factor_scoreboard sb = new();

	prime_factor_count_prefix_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= rx_idle);
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task send_beat(input logic kind, input logic [IDX_W-1:0] a, input logic [IDX_W-1:0] b);
		while ($urandom_range(0, 99) < tx_idle) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= {b, a};
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_input(kind, a, b);
	endtask

	task drain_results();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (sb.pending_results.size() != 0)
			@(posedge clk);
	endtask

	task write_limit(input logic [IDX_W-1:0] value);
		drain_results();
		repeat (8) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_limit(value);
	endtask

	function automatic logic [IDX_W-1:0] pick_limit();
		int r;
		r = $urandom_range(0, 15);
		if (r == 0)
			return 16'd2;
		else if (r == 1)
			return 16'($urandom_range(1000, 3000));
		return 16'($urandom_range(3, 300));
	endfunction

	task send_random_query();
		logic [IDX_W-1:0] a;
		logic [IDX_W-1:0] b;
		int unsigned lim;
		int pick;
		lim = sb.built_lim;
		pick = $urandom_range(0, 99);
		if (pick < 75) begin
			a = 16'((pick < 8) ? lim : $urandom_range(1, lim));
			b = 16'((pick < 4) ? 32'(a) : $urandom_range(1, a));
		end else begin
			case (pick % 4)
				0: begin
					a = 16'($urandom);
					b = 16'($urandom);
				end
				1: begin
					a = 16'($urandom_range(0, lim));
					b = 16'($urandom_range(0, lim));
					if (pick[0])
						a = '0;
					else
						b = '0;
				end
				2: begin
					a = 16'((lim < 65535) ? $urandom_range(lim + 1, 65535) : 65535);
					b = 16'($urandom_range(1, lim));
					if (pick[3])
						{a, b} = {b, a};
				end
				default: begin
					a = 16'($urandom_range(1, lim - 1));
					b = 16'($urandom_range(a + 1, lim));
				end
			endcase
		end
		send_beat(KIND_QUERY, a, b);
	endtask

	initial begin
		int sent;
		int seg;
		int r;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_beat(KIND_QUERY, 16'd5, 16'd3);
		send_beat(KIND_QUERY, 16'hFFFF, 16'd0);
		write_limit(16'd65535);
		send_beat(KIND_BUILD, 16'hFFFF, 16'hFFFF);
		send_beat(KIND_QUERY, 16'd65535, 16'd1);
		send_beat(KIND_QUERY, 16'd65535, 16'd65535);
		send_beat(KIND_QUERY, 16'd1, 16'd1);
		send_beat(KIND_QUERY, 16'd2, 16'd1);
		send_beat(KIND_QUERY, 16'd65535, 16'd65534);
		send_beat(KIND_QUERY, 16'd12, 16'd11);
		send_beat(KIND_QUERY, 16'd0, 16'd5);
		send_beat(KIND_QUERY, 16'd5, 16'd0);
		send_beat(KIND_QUERY, 16'd0, 16'd0);
		send_beat(KIND_QUERY, 16'd6, 16'd7);
		send_beat(KIND_QUERY, 16'd1, 16'd65535);
		write_limit(16'd2);
		send_beat(KIND_QUERY, 16'd100, 16'd3);
		send_beat(KIND_BUILD, 16'd0, 16'd0);
		send_beat(KIND_QUERY, 16'd2, 16'd1);
		send_beat(KIND_QUERY, 16'd3, 16'd1);
		write_limit(16'd1);
		send_beat(KIND_BUILD, 16'd0, 16'd0);
		send_beat(KIND_QUERY, 16'd1, 16'd1);
		send_beat(KIND_QUERY, 16'd2, 16'd1);
		write_limit(16'd0);
		send_beat(KIND_BUILD, 16'd0, 16'd0);
		send_beat(KIND_QUERY, 16'd1, 16'd1);

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					tx_idle = 30;
					rx_idle = 60;
				end
				1: begin
					tx_idle = 60;
					rx_idle = 30;
				end
				default: begin
					tx_idle = 0;
					rx_idle = 0;
				end
			endcase
			sent = 0;
			while (sent < BEATS_PER_PHASE) begin
				write_limit(pick_limit());
				if (sb.built_lim < 2 || $urandom_range(0, 3) != 0) begin
					send_beat(KIND_BUILD, 16'($urandom), 16'($urandom));
					sent++;
				end
				seg = $urandom_range(20, 60);
				if (seg > BEATS_PER_PHASE - sent)
					seg = BEATS_PER_PHASE - sent;
				repeat (seg) begin
					r = $urandom_range(0, 99);
					if (r < 2)
						drain_results();
					if (r < 4)
						send_beat(KIND_BUILD, 16'($urandom), 16'($urandom));
					else
						send_random_query();
					sent++;
				end
			end
		end

		drain_results();
		repeat (20) @(posedge clk);
		if (sb.errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
